// ===== rtl/ssil_pkg.sv =====
// Shared types and constants for the sorted set insert/lookup block.
// Used by the controller, the datapath and the top level; no dependencies.
package ssil_pkg;

   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 5;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request, clear index and flags
      logic scan_rd;     // read the entry at the index
      logic scan_next;   // step the index up by one
      logic scan_hit;    // stop the scan here, latch equality
      logic set_full;    // refuse the insert
      logic shift_init;  // remember the insert position, index to count
      logic shift_rd;    // read the entry below the index
      logic shift_wr;    // write that entry one place up, step index down
      logic place;       // write the new value at the index
      logic emit;        // load the result register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic at_count;    // index equals the element count
      logic less;        // read entry is below the searched value
      logic is_full;     // set holds DEPTH entries
      logic at_pos;      // index equals the insert position
      logic is_lookup;   // current transaction is a lookup
      logic found;       // value was found by the scan
      logic rsp_busy;    // result register holds an untaken result
   } dp_stat_type;

endpackage

// ===== rtl/ssil_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ssil_ctrl.sv =====
// Controller state machine for the sorted set: scan, shift, place, respond.
// Depends on ssil_pkg for the command and status structs.
module ssil_ctrl
   import ssil_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.at_count) begin
               state_in = S_DECIDE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.less) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN;
            end else begin
               cmd.scan_hit = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_lookup || stat.found) begin
               state_in = S_EMIT;
            end else if (stat.is_full) begin
               cmd.set_full = 1'b1;
               state_in     = S_EMIT;
            end else begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.at_pos) begin
               state_in = S_PLACE;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (!stat.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

endmodule

// ===== rtl/ssil_dp.sv =====
// Datapath for the sorted set: request registers, index, count, entry RAM
// and result register. Depends on ssil_pkg and ssil_ram.
module ssil_dp
   import ssil_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_mode,
   input  logic signed [31:0] req_value,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic               rsp_added,
   output logic               rsp_full_res,
   output logic [4:0]         rsp_count,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic               mode_ff;
   logic signed [31:0] value_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      pos_ff;
   logic [CW-1:0]      count_ff;
   logic               found_ff;
   logic               full_ff;
   logic               added_ff;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic               rsp_added_ff;
   logic               rsp_full_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [CW-1:0]          idx_dec;
   logic [CW+COUNT_W-1:0]  count_ext;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [VALUE_W-1:0]     ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [VALUE_W-1:0]     ram_rd_data;

   assign idx_dec   = idx_ff - ONE_C;
   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   // During a shift the index walks down from the count; each read fetches
   // the entry below it, and the following write moves that entry up.
   assign ram_rd_en   = cmd.scan_rd | cmd.shift_rd;
   assign ram_rd_addr = cmd.shift_rd ? idx_dec[AW-1:0] : idx_ff[AW-1:0];
   assign ram_wr_en   = cmd.shift_wr | cmd.place;
   assign ram_wr_addr = idx_ff[AW-1:0];
   assign ram_wr_data = cmd.place ? value_ff : ram_rd_data;

   ssil_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
      if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.scan_next) begin
         idx_ff <= idx_ff + ONE_C;
      end else if (cmd.shift_init) begin
         idx_ff <= count_ff;
      end else if (cmd.shift_wr) begin
         idx_ff <= idx_dec;
      end
      if (cmd.shift_init) begin
         pos_ff <= idx_ff;
      end
      if (cmd.load) begin
         found_ff <= 1'b0;
         full_ff  <= 1'b0;
         added_ff <= 1'b0;
      end else begin
         if (cmd.scan_hit) begin
            found_ff <= ($signed(ram_rd_data) == value_ff);
         end
         if (cmd.set_full) begin
            full_ff <= 1'b1;
         end
         if (cmd.place) begin
            added_ff <= 1'b1;
         end
      end
      if (cmd.emit) begin
         rsp_found_ff <= found_ff;
         rsp_added_ff <= added_ff;
         rsp_full_ff  <= full_ff;
         rsp_count_ff <= count_ext[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.place) begin
            count_ff <= count_ff + ONE_C;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.at_count  = (idx_ff == count_ff);
   assign stat.less      = ($signed(ram_rd_data) < value_ff);
   assign stat.is_full   = (count_ff == DEPTH_C);
   assign stat.at_pos    = (idx_ff == pos_ff);
   assign stat.is_lookup = (mode_ff == MODE_LOOKUP);
   assign stat.found     = found_ff;
   assign stat.rsp_busy  = rsp_valid_ff & rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_added    = rsp_added_ff;
   assign rsp_full_res = rsp_full_ff;
   assign rsp_count    = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("element count exceeds table depth");

   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> (count_ff < DEPTH_C) && !found_ff)
      else $error("new element placed into a full table or over a duplicate");

   a_place_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> count_ff == $past(count_ff) + ONE_C)
      else $error("count did not advance after placing an element");

   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_added_ff && (rsp_found_ff || rsp_full_ff)))
      else $error("result reports an add together with found or full");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");
`endif

endmodule

// ===== rtl/sorted_set_insert_lookup.sv =====
// Top level of the sorted set insert/lookup block.
// Depends on ssil_pkg, ssil_ctrl and ssil_dp (which holds ssil_ram).
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   req_mode, req_value
//   rsp_      out         rsp_valid / rsp_stall   rsp_found, rsp_added,
//                                                 rsp_full_res, rsp_count
//
// The RAM read is registered, so the scan spends a read state and a check state on
// each entry below the value, and an insert moves each larger entry up with a read
// state and a write state.
// Reset clears the element count at once; the entry RAM needs no clearing.
// A waiting result sits in the output register, and the next transaction is
// accepted meanwhile; rsp_stall only holds the block before it emits again.
module sorted_set_insert_lookup
   import ssil_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic               rsp_added,
   output logic               rsp_full_res,
   output logic [4:0]         rsp_count
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ssil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssil_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_added    (rsp_added),
      .rsp_full_res (rsp_full_res),
      .rsp_count    (rsp_count),
      .cmd          (cmd),
      .stat         (stat)
   );

endmodule
